// ===== sv/oqrbv_pkg.sv =====
// Package for the ordered queue with remove by value.
// Holds sizes, opcode and status codes, item structs and control structs.
// No dependencies.
package oqrbv_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [5:0]         entry_count;
    logic               last_of_run;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic remove;
    logic ld_op;
    logic ld_dump;
    logic ld_empty;
    logic last;
    idx_t idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    cnt_t count;
    logic empty;
  } dp_status_t;

endpackage

// ===== sv/ordered_queue_remove_by_value.sv =====
// Ordered queue of signed 32-bit values, capacity DEPTH (package constant).
// Append writes at the tail; remove of the first entry equal to a key uses
// the entry cells, which compare against the key in parallel and shift up in place.
// The next item is taken once the output register is empty, or in the same
// cycle that its waiting result leaves.
// A dump enters its own sequence: a start state, then one item per entry held
// at one item per cycle while the output register is free (head first,
// last_of_run on the tail entry), with no input taken before the cycle in
// which the tail entry leaves the output register; an empty dump gives one
// item with the empty status. Opcode 3 is ignored and gives no item.
// Depends on oqrbv_pkg, oqrbv_ctrl and oqrbv_dpath.
module ordered_queue_remove_by_value import oqrbv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t       cmd;
  dp_status_t dp_status;

  oqrbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_item_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  oqrbv_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .status_o   (dp_status),
    .out_item_o (out_item_o)
  );

endmodule

// ===== sv/oqrbv_dpath.sv =====
// Datapath of the ordered queue: a chain of entry cells with parallel compare
// and shift, the occupancy counter and the output payload register.
// Depends on oqrbv_pkg.
module oqrbv_dpath import oqrbv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  in_item_t   in_item_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);

  logic signed [31:0] cells_q [DEPTH];
  cnt_t               count_q, count_d;
  out_item_t          out_q, out_d;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] shift_en;
  logic             found;
  logic             full;
  logic [1:0]       op_status;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      match[k] = (cnt_t'(k) < count_q) && (cells_q[k] == in_item_i.value);
    end
  end

  // lowest matching cell, and every cell from there up
  assign first    = match & (~match + DEPTH'(1));
  assign shift_en = ~(first - DEPTH'(1));
  assign found    = |match;
  assign full     = (count_q == cnt_t'(DEPTH));

  always_comb begin
    count_d   = count_q;
    op_status = STAT_OK;
    if (cmd_i.append) begin
      if (full) begin
        op_status = STAT_FULL;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end else if (cmd_i.remove) begin
      if (found) begin
        count_d = count_q - cnt_t'(1);
      end else begin
        op_status = STAT_NOTFOUND;
      end
    end
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.ld_op) begin
      out_d.status      = op_status;
      out_d.entry_value = in_item_i.value;
      out_d.entry_count = 6'(count_d);
      out_d.last_of_run = 1'b1;
    end else if (cmd_i.ld_dump) begin
      out_d.status      = STAT_OK;
      out_d.entry_value = cells_q[cmd_i.idx];
      out_d.entry_count = 6'(count_q);
      out_d.last_of_run = cmd_i.last;
    end else if (cmd_i.ld_empty) begin
      out_d.status      = STAT_EMPTY;
      out_d.entry_value = '0;
      out_d.entry_count = 6'(count_q);
      out_d.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      cells_q[count_q[IdxW-1:0]] <= in_item_i.value;
    end else if (cmd_i.remove && found) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        if (shift_en[k]) begin
          cells_q[k] <= cells_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign out_item_o     = out_q;

endmodule

// ===== sv/oqrbv_ctrl.sv =====
// Controller of the ordered queue: decodes opcodes, sequences a dump and owns
// the output valid flag.
// Depends on oqrbv_pkg.
module oqrbv_ctrl import oqrbv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output cmd_t       cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic state_q, state_d;
  idx_t idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  logic accept;
  logic last;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = ((cnt_t'(idx_q) + cnt_t'(1)) == status_i.count);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    cmd_o.last = last;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_APPEND: begin
              cmd_o.append = 1'b1;
              cmd_o.ld_op  = 1'b1;
            end
            OP_REMOVE: begin
              cmd_o.remove = 1'b1;
              cmd_o.ld_op  = 1'b1;
            end
            OP_DUMP: begin
              if (status_i.empty) begin
                cmd_o.ld_empty = 1'b1;
              end else begin
                state_d = ST_DUMP;
                idx_d   = '0;
              end
            end
            default: ;  // unused opcode: no effect, no item out
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd_o.ld_dump = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + idx_t'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_op || cmd_o.ld_dump || cmd_o.ld_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_dump_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !in_ready_o)
    else $error("input taken during dump");

  a_dump_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (cnt_t'(idx_q) < status_i.count))
    else $error("dump index beyond occupancy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.count <= cnt_t'(DEPTH))
    else $error("occupancy above capacity");

  a_op_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_APPEND || opcode_i == OP_REMOVE)) |=> out_valid_q)
    else $error("append or remove gave no item");
`endif

endmodule

// ===== tb/tb_ordered_queue_remove_by_value.sv =====
// Testbench for ordered_queue_remove_by_value: a directed table, then random traffic
// checked against a queue-based predictor, with random stalls on both channels.
// Depends on oqrbv_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_ordered_queue_remove_by_value;
  import oqrbv_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomItems = 140;
  localparam int LongHold    = 200;
  localparam int TailCycles  = 40;
  localparam int CycleLimit  = 1_000_000;
  localparam int DirRows     = 20;

  typedef struct packed {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  logic signed [31:0] shadow_entries[$];
  out_item_t          pending_results[$];
  int                 mismatches   = 0;
  int                 results_seen = 0;
  int                 cycle_count  = 0;

  // rows with a typed result are checked against it, the rest against the predictor
  dir_row_t dir_tab [DirRows] = '{
    '{'{OP_DUMP,   32'h0000_0000}, 1'b1, '{STAT_EMPTY,    32'h0000_0000, 6'd0, 1'b1}},
    '{'{OP_REMOVE, 32'h0000_0005}, 1'b1, '{STAT_NOTFOUND, 32'h0000_0005, 6'd0, 1'b1}},
    '{'{OpUnused,  32'h1234_5678}, 1'b0, '0},
    '{'{OP_APPEND, 32'h0000_0005}, 1'b1, '{STAT_OK,       32'h0000_0005, 6'd1, 1'b1}},
    '{'{OP_REMOVE, 32'h0000_0005}, 1'b1, '{STAT_OK,       32'h0000_0005, 6'd0, 1'b1}},
    '{'{OP_DUMP,   32'hFFFF_FFFF}, 1'b1, '{STAT_EMPTY,    32'h0000_0000, 6'd0, 1'b1}},
    '{'{OP_APPEND, 32'h7FFF_FFFF}, 1'b1, '{STAT_OK,       32'h7FFF_FFFF, 6'd1, 1'b1}},
    '{'{OP_APPEND, 32'h8000_0000}, 1'b1, '{STAT_OK,       32'h8000_0000, 6'd2, 1'b1}},
    '{'{OP_APPEND, 32'h0000_0000}, 1'b1, '{STAT_OK,       32'h0000_0000, 6'd3, 1'b1}},
    '{'{OP_APPEND, 32'hFFFF_FFFF}, 1'b1, '{STAT_OK,       32'hFFFF_FFFF, 6'd4, 1'b1}},
    '{'{OP_APPEND, 32'h0000_0007}, 1'b0, '0},
    '{'{OP_APPEND, 32'h0000_0007}, 1'b0, '0},
    '{'{OP_APPEND, 32'h5555_5555}, 1'b0, '0},
    '{'{OP_DUMP,   32'hAAAA_AAAA}, 1'b0, '0},
    '{'{OP_REMOVE, 32'h0000_0007}, 1'b0, '0},
    '{'{OP_REMOVE, 32'h0000_0064}, 1'b0, '0},
    '{'{OP_REMOVE, 32'h7FFF_FFFF}, 1'b0, '0},
    '{'{OP_REMOVE, 32'h5555_5555}, 1'b0, '0},
    '{'{OpUnused,  32'hAAAA_AAAA}, 1'b0, '0},
    '{'{OP_DUMP,   32'h0000_0000}, 1'b0, '0}
  };

  ordered_queue_remove_by_value DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // updates the shadow queue and, if keep is set, queues the results it causes
  task automatic apply_to_shadow(input in_item_t it, input bit keep);
    int        hit;
    out_item_t res;
    hit = -1;
    res = '0;
    res.entry_value = it.value;
    res.last_of_run = 1'b1;
    case (it.opcode)
      OP_APPEND: begin
        if (shadow_entries.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_entries.push_back(it.value);
          res.status = STAT_OK;
        end
      end
      OP_REMOVE: begin
        foreach (shadow_entries[i]) begin
          if (hit < 0 && shadow_entries[i] == it.value) hit = i;
        end
        if (hit < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          shadow_entries.delete(hit);
          res.status = STAT_OK;
        end
      end
      OP_DUMP: begin
        if (shadow_entries.size() == 0) begin
          res.status      = STAT_EMPTY;
          res.entry_value = '0;
        end else begin
          foreach (shadow_entries[i]) begin
            res.status      = STAT_OK;
            res.entry_value = shadow_entries[i];
            res.entry_count = 6'(shadow_entries.size());
            res.last_of_run = (i == shadow_entries.size() - 1);
            if (keep) pending_results.push_back(res);
          end
          return;
        end
      end
      default: return;
    endcase
    res.entry_count = 6'(shadow_entries.size());
    if (keep) pending_results.push_back(res);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: status %0d value %0d count %0d last %0d",
                 got.status, got.entry_value, got.entry_count, got.last_of_run);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.entry_value !== want.entry_value ||
          got.entry_count !== want.entry_count || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on item %0d: status %0d/%0d value %0d/%0d count %0d/%0d last %0d/%0d",
                   results_seen, want.status, got.status, want.entry_value, got.entry_value,
                   want.entry_count, got.entry_count, want.last_of_run, got.last_of_run);
      end
    end
  endtask

  // holds valid with a fixed payload until the item is taken
  task automatic offer(input in_item_t it, input bit keep);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_shadow(it, keep);
  endtask

  task automatic hold_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mostly back to back or short, now and then a long gap
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic in_item_t pick_item(input int phase);
    in_item_t it;
    int       r;
    int       hit_pct;
    int       append_pct;
    int       remove_pct;
    case (phase)
      0: begin append_pct = 88; remove_pct = 94; end
      2: begin append_pct = 15; remove_pct = 85; end
      default: begin append_pct = 45; remove_pct = 80; end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 4) it.opcode = OpUnused;
    else if (r < append_pct) it.opcode = OP_APPEND;
    else if (r < remove_pct) it.opcode = OP_REMOVE;
    else it.opcode = OP_DUMP;
    hit_pct = (it.opcode == OP_REMOVE) ? 70 : 25;
    r = $urandom_range(0, 99);
    if (shadow_entries.size() != 0 && r < hit_pct)
      it.value = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
    else if (r > 84)
      it.value = corner_value();
    else
      it.value = $urandom;
    return it;
  endfunction

  initial begin : sender
    in_item_t it;
    int       sent;
    bit       drained;
    sent    = 0;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[k]) begin
      hold_input(pick_gap(1'b0));
      offer(dir_tab[k].stim, !dir_tab[k].typed);
      if (dir_tab[k].typed) pending_results.push_back(dir_tab[k].want);
    end
    while (sent < RandomItems) begin
      if (sent == 100 && !drained) begin
        // let the output side run dry before going on
        drained  = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      it = pick_item(sent / 45);
      hold_input(pick_gap((sent / 20) % 4 == 2));
      offer(it, 1'b1);
      if (it.opcode != OpUnused) sent++;
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int  stall_left;
    int  r;
    bit  long_done;
    stall_left = 0;
    long_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result(out_item);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_done && results_seen >= 40) begin
        // long hold-off so the block backs up and stops taking input
        long_done  = 1'b1;
        stall_left = LongHold;
        out_ready  <= 1'b0;
      end else if ((results_seen / 25) % 3 == 2) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
          out_ready  <= 1'b0;
        end
      end
    end
  end

endmodule
